// File: rtl/rke_pkg.sv
`timescale 1ns / 1ps

package rke_pkg;

	localparam int KMER_W = 64;
	localparam int BYTE_W = 8;
	localparam int KLEN_W = 6;

	typedef logic [1:0]        code_t;
	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [KLEN_W-1:0] klen_t;

	localparam byte_t CHAR_NL   = 8'h0A;
	localparam byte_t CHAR_A_UP = 8'h41;
	localparam byte_t CHAR_C_UP = 8'h43;
	localparam byte_t CHAR_G_UP = 8'h47;
	localparam byte_t CHAR_T_UP = 8'h54;
	localparam byte_t CHAR_A_LO = 8'h61;
	localparam byte_t CHAR_C_LO = 8'h63;
	localparam byte_t CHAR_G_LO = 8'h67;
	localparam byte_t CHAR_T_LO = 8'h74;

	localparam code_t CODE_A = 2'd0;
	localparam code_t CODE_C = 2'd1;
	localparam code_t CODE_G = 2'd2;
	localparam code_t CODE_T = 2'd3;

	localparam klen_t KLEN_RESET = 6'd16;

	function automatic code_t base_code(input byte_t b);
		code_t c;
		case (b)
			CHAR_T_UP, CHAR_T_LO: c = CODE_T;
			CHAR_G_UP, CHAR_G_LO: c = CODE_G;
			CHAR_C_UP, CHAR_C_LO: c = CODE_C;
			default:              c = CODE_A;
		endcase
		return c;
	endfunction

	function automatic logic is_acgt(input byte_t b);
		logic r;
		case (b)
			CHAR_A_UP, CHAR_C_UP, CHAR_G_UP, CHAR_T_UP,
			CHAR_A_LO, CHAR_C_LO, CHAR_G_LO, CHAR_T_LO: r = 1'b1;
			default:                                    r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/rke_ifs.sv
`timescale 1ns / 1ps

interface rke_cfg_if import rke_pkg::*; ();
	logic  valid;
	logic  ready;
	klen_t kmer_length;

	modport source (output valid, output kmer_length, input ready);
	modport sink (input valid, input kmer_length, output ready);
endinterface

interface rke_in_if import rke_pkg::*; ();
	logic  valid;
	logic  ready;
	byte_t text_byte;
	logic  new_file;

	modport source (output valid, output text_byte, output new_file, input ready);
	modport sink (input valid, input text_byte, input new_file, output ready);
endinterface

interface rke_out_if import rke_pkg::*; #(
	parameter int POS_W = 40
) ();
	logic              valid;
	logic              ready;
	logic [KMER_W-1:0] forward_kmer;
	logic [KMER_W-1:0] reverse_kmer;
	logic              ambiguous;
	logic [POS_W-1:0]  position;

	modport source (
		output valid, output forward_kmer, output reverse_kmer,
		output ambiguous, output position, input ready
	);
	modport sink (
		input valid, input forward_kmer, input reverse_kmer,
		input ambiguous, input position, output ready
	);
endinterface

// File: rtl/rke_revcomp.sv
`timescale 1ns / 1ps

module rke_revcomp import rke_pkg::*; #(
	parameter int MAX_K = 32
) (
	input  logic [2*MAX_K-1:0] window,
	input  klen_t              k,
	output logic [2*MAX_K-1:0] revcomp
);

	localparam logic [6:0] MAXK7 = 7'(MAX_K);

	logic [2*MAX_K-1:0] rev_full;
	logic [6:0]         kdiff;
	logic [6:0]         shamt;

	always_comb begin
		for (int i = 0; i < MAX_K; i++) begin
			rev_full[2*(MAX_K-1-i) +: 2] = ~window[2*i +: 2];
		end
	end

	// drop the complemented empty slots above the k-th base
	assign kdiff   = MAXK7 - {1'b0, k};
	assign shamt   = {kdiff[5:0], 1'b0};
	assign revcomp = rev_full >> shamt;

endmodule

// File: rtl/rolling_kmer_extractor.sv
`timescale 1ns / 1ps

// Rolling k-mer extractor for FASTA text.
// Channels: text (sink) takes one byte per item plus a new_file mark; kmer
// (source) gives one item per base once k bases are in the window: forward
// k-mer, reverse complement, ambiguity flag and start position. cfg (sink)
// writes kmer_length (0 acts as 1, above MAX_K acts as MAX_K); it is always
// ready and should be written only while the block is idle.
// A result item is registered and appears on kmer in the cycle after its byte is taken.
// Throughput: one byte per cycle while kmer keeps up; header bytes and newlines give no item.
// The window, fill and ambiguity state and the result register form one
// stage, so a byte can be taken every cycle while the kmer side keeps up.
// Stall: when kmer holds a result that is not taken, text.ready drops; it
// stays high while the held result is being taken in that same cycle.
// Reset: arst_n clears the window, counters and position, enters header
// skip and sets kmer_length to 16. new_file does the same (keeping
// kmer_length) before its own byte is handled.
module rolling_kmer_extractor import rke_pkg::*; #(
	parameter int MAX_K         = 32,
	parameter int POSITION_BITS = 40
) (
	input  logic      clk,
	input  logic      arst_n,
	rke_cfg_if.sink   cfg,
	rke_in_if.sink    text,
	rke_out_if.source kmer
);

	localparam int WIN_W = 2 * MAX_K;
	localparam klen_t MAXK6 = 6'(MAX_K);

	klen_t                    kmer_length_q;
	logic [WIN_W-1:0]         window_q;
	klen_t                    amb_count_q;
	klen_t                    fill_q;
	logic                     in_header_q;
	logic [POSITION_BITS-1:0] pos_q;

	logic                     out_valid_s1;
	logic [WIN_W-1:0]         fwd_s1;
	logic [WIN_W-1:0]         rev_s1;
	logic                     amb_s1;
	logic [POSITION_BITS-1:0] pos_s1;

	klen_t                    k_eff;
	logic                     accept;
	logic [WIN_W-1:0]         window_base;
	klen_t                    amb_base;
	klen_t                    fill_base;
	logic                     hdr_base;
	logic [POSITION_BITS-1:0] pos_base;

	logic [WIN_W-1:0]         window_d;
	klen_t                    amb_d;
	klen_t                    fill_d;
	logic                     hdr_d;
	logic [POSITION_BITS-1:0] pos_d;
	logic                     amb_flag;
	logic                     emit;
	logic [WIN_W-1:0]         win_mask;
	logic [WIN_W-1:0]         rev_w;
	klen_t                    amb_pre;

	always_comb begin
		if (kmer_length_q == '0) begin
			k_eff = 6'd1;
		end else if (kmer_length_q > MAXK6) begin
			k_eff = MAXK6;
		end else begin
			k_eff = kmer_length_q;
		end
	end

	assign cfg.ready  = 1'b1;
	assign text.ready = !out_valid_s1 || kmer.ready;
	assign accept     = text.valid && text.ready;

	assign window_base = text.new_file ? '0 : window_q;
	assign amb_base    = text.new_file ? '0 : amb_count_q;
	assign fill_base   = text.new_file ? '0 : fill_q;
	assign hdr_base    = text.new_file ? 1'b1 : in_header_q;
	assign pos_base    = text.new_file ? '0 : pos_q;

	assign win_mask = ~({WIN_W{1'b1}} << {k_eff, 1'b0});

	always_comb begin
		window_d = window_base;
		amb_d    = amb_base;
		fill_d   = fill_base;
		hdr_d    = hdr_base;
		pos_d    = pos_base;
		amb_flag = 1'b0;
		emit     = 1'b0;
		amb_pre  = is_acgt(text.text_byte) ? amb_base : k_eff;
		if (hdr_base) begin
			if (text.text_byte == CHAR_NL) begin
				hdr_d = 1'b0;
			end
		end else if (text.text_byte != CHAR_NL) begin
			if (amb_pre != '0) begin
				amb_flag = 1'b1;
				amb_d    = amb_pre - 6'd1;
			end else begin
				amb_d = amb_pre;
			end
			window_d = ({window_base[WIN_W-3:0], 2'b00}
			           | WIN_W'(base_code(text.text_byte))) & win_mask;
			if (fill_base < k_eff) begin
				fill_d = fill_base + 6'd1;
			end
			emit = (fill_d >= k_eff);
			if (emit && pos_base != '1) begin
				pos_d = pos_base + 1'b1;
			end
		end
	end

	rke_revcomp #(
		.MAX_K (MAX_K)
	) u_revcomp (
		.window  (window_d),
		.k       (k_eff),
		.revcomp (rev_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= KLEN_RESET;
			window_q      <= '0;
			amb_count_q   <= '0;
			fill_q        <= '0;
			in_header_q   <= 1'b1;
			pos_q         <= '0;
			out_valid_s1  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				kmer_length_q <= cfg.kmer_length;
			end
			if (accept) begin
				window_q    <= window_d;
				amb_count_q <= amb_d;
				fill_q      <= fill_d;
				in_header_q <= hdr_d;
				pos_q       <= pos_d;
			end
			if (accept && emit) begin
				out_valid_s1 <= 1'b1;
			end else if (kmer.ready) begin
				out_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			fwd_s1 <= window_d;
			rev_s1 <= rev_w;
			amb_s1 <= amb_flag;
			pos_s1 <= pos_base;
		end
	end

	assign kmer.valid        = out_valid_s1;
	assign kmer.forward_kmer = KMER_W'(fwd_s1);
	assign kmer.reverse_kmer = KMER_W'(rev_s1);
	assign kmer.ambiguous    = amb_s1;
	assign kmer.position     = pos_s1;

endmodule
